// ===== src/cpts_pkg.sv =====
// shared types and constants for the cost preference table sort unit
// table geometry, operation and register codes, table entry and ram port types
package cpts_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int ADDR_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SORT  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_SORT_LOW  = 2'd0;
  localparam logic [1:0] REG_SORT_HIGH = 2'd1;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [3:0]         id;
    logic signed [31:0] cost;
  } entry_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    logic   re;
    addr_t  raddr;
  } ram_req_t;

endpackage

// ===== src/cpts_table.sv =====
// slot table: one write and one read port, read data registered
// per-slot valid bits make unwritten slots read as zero; depends on cpts_pkg
module cpts_table (
  input  logic              clk,
  input  logic              rst_n,
  input  cpts_pkg::ram_req_t req,
  output cpts_pkg::entry_t   rd_data
);

  cpts_pkg::entry_t                       mem [cpts_pkg::TABLE_SLOTS];
  logic [cpts_pkg::TABLE_SLOTS-1:0]       valid_r;
  cpts_pkg::entry_t                       rd_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  // a read of the slot being written sees the new word
  always_ff @(posedge clk) begin
    if (req.re) begin
      if (req.we && (req.waddr == req.raddr)) begin
        rd_r <= req.wdata;
      end else if (valid_r[req.raddr]) begin
        rd_r <= mem[req.raddr];
      end else begin
        rd_r <= '0;
      end
    end
  end

  assign rd_data = rd_r;

endmodule

// ===== src/cost_preference_table_sort_unit.sv =====
// top level of the cost preference table sort unit
// sequencer around the slot table (cpts_table); depends on cpts_pkg
//
// Holds a table of (node id, cost) slots in one single-port-read ram. A write
// word stores (index, cost) at slot index and echoes it, a read word reports
// a slot, a sort word reorders slots sort_low..sort_high (sort_high capped at
// the last slot) into descending cost, ties by ascending id, and reports slot
// sort_low. One word is in work at a time: a write goes straight to the
// response state, a read passes the read wait state first. A sort is an
// insertion sort run against the ram, one slot at a time: each key after the
// first is read, each slot that it goes before is shifted up, the key is
// written in place, and at the end slot sort_low is read back and reported.
// A finished result waits in the output register while the next word enters.
module cost_preference_table_sort_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_index,
  input  logic signed [31:0] in_cost,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_node_id,
  output logic signed [31:0] out_node_cost,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [3:0]         cfg_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RDWAIT = 3'd1;
  localparam logic [2:0] ST_KEY    = 3'd2;
  localparam logic [2:0] ST_CMP    = 3'd3;
  localparam logic [2:0] ST_INS    = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  cpts_pkg::addr_t   i_r, i_nxt;
  cpts_pkg::addr_t   j_r, j_nxt;
  cpts_pkg::addr_t   lo_r, lo_nxt;
  cpts_pkg::addr_t   hi_r, hi_nxt;
  cpts_pkg::entry_t  key_r, key_nxt;
  cpts_pkg::entry_t  res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  cpts_pkg::entry_t  out_data_r, out_data_nxt;
  logic [3:0]        sort_low_r, sort_high_r;

  cpts_pkg::ram_req_t req;
  cpts_pkg::entry_t   rd;
  cpts_pkg::addr_t    hi_sat;
  cpts_pkg::addr_t    j_dec;
  logic               advance;

  function automatic logic in_table(input logic [3:0] v);
    in_table = int'(v) < cpts_pkg::TABLE_SLOTS;
  endfunction

  // true if a must sit before b: higher cost first, then lower id
  function automatic logic goes_before(input cpts_pkg::entry_t a,
                                       input cpts_pkg::entry_t b);
    if (a.cost != b.cost) begin
      goes_before = $signed(a.cost) > $signed(b.cost);
    end else begin
      goes_before = a.id < b.id;
    end
  endfunction

  cpts_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd)
  );

  assign in_stall      = state_r != ST_IDLE;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_node_id   = out_data_r.id;
  assign out_node_cost = out_data_r.cost;

  assign hi_sat = (int'(sort_high_r) > cpts_pkg::TABLE_SLOTS - 1)
                  ? cpts_pkg::addr_t'(cpts_pkg::TABLE_SLOTS - 1)
                  : cpts_pkg::addr_t'(sort_high_r);
  assign j_dec  = j_r - cpts_pkg::addr_t'(1);

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    advance       = 1'b0;
    req           = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            cpts_pkg::OP_WRITE: begin
              res_nxt = '0;
              if (in_table(in_index)) begin
                req.we    = 1'b1;
                req.waddr = cpts_pkg::addr_t'(in_index);
                req.wdata = '{id: in_index, cost: in_cost};
                res_nxt   = '{id: in_index, cost: in_cost};
              end
              state_nxt = ST_RESP;
            end
            cpts_pkg::OP_SORT: begin
              if (int'(sort_low_r) < int'(hi_sat)) begin
                lo_nxt    = cpts_pkg::addr_t'(sort_low_r);
                hi_nxt    = hi_sat;
                i_nxt     = cpts_pkg::addr_t'(sort_low_r) + cpts_pkg::addr_t'(1);
                req.re    = 1'b1;
                req.raddr = cpts_pkg::addr_t'(sort_low_r) + cpts_pkg::addr_t'(1);
                state_nxt = ST_KEY;
              end else if (in_table(sort_low_r)) begin
                req.re    = 1'b1;
                req.raddr = cpts_pkg::addr_t'(sort_low_r);
                state_nxt = ST_RDWAIT;
              end else begin
                res_nxt   = '0;
                state_nxt = ST_RESP;
              end
            end
            cpts_pkg::OP_READ: begin
              if (in_table(in_index)) begin
                req.re    = 1'b1;
                req.raddr = cpts_pkg::addr_t'(in_index);
                state_nxt = ST_RDWAIT;
              end else begin
                res_nxt   = '0;
                state_nxt = ST_RESP;
              end
            end
            default: begin
              res_nxt   = '0;
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        res_nxt   = rd;
        state_nxt = ST_RESP;
      end
      ST_KEY: begin
        key_nxt   = rd;
        j_nxt     = i_r;
        req.re    = 1'b1;
        req.raddr = i_r - cpts_pkg::addr_t'(1);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (goes_before(key_r, rd)) begin
          // shift the neighbor up one slot and keep walking down
          req.we    = 1'b1;
          req.waddr = j_r;
          req.wdata = rd;
          j_nxt     = j_dec;
          if (j_dec != lo_r) begin
            req.re    = 1'b1;
            req.raddr = j_dec - cpts_pkg::addr_t'(1);
          end else begin
            state_nxt = ST_INS;
          end
        end else begin
          req.we    = 1'b1;
          req.waddr = j_r;
          req.wdata = key_r;
          advance   = 1'b1;
        end
      end
      ST_INS: begin
        req.we    = 1'b1;
        req.waddr = j_r;
        req.wdata = key_r;
        advance   = 1'b1;
      end
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // next key, or read back the first slot of the range for the report
    if (advance) begin
      req.re = 1'b1;
      if (i_r == hi_r) begin
        req.raddr = lo_r;
        state_nxt = ST_RDWAIT;
      end else begin
        i_nxt     = i_r + cpts_pkg::addr_t'(1);
        req.raddr = i_r + cpts_pkg::addr_t'(1);
        state_nxt = ST_KEY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sort_low_r  <= 4'd0;
      sort_high_r <= 4'd15;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cpts_pkg::REG_SORT_LOW:  sort_low_r  <= cfg_data;
          cpts_pkg::REG_SORT_HIGH: sort_high_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    key_r      <= key_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
